// ----- rtl/core/qcmr_pkg.sv -----
// Shared types and constants for the quantized conv MAC / requantize block.
`timescale 1ns / 1ps

package qcmr_pkg;

    // Widths fixed by the item fields.
    localparam int ACT_W    = 8;
    localparam int WGT_W    = 8;
    localparam int MULT_W   = 32;
    localparam int OFFS_W   = 48;
    localparam int SHIFT_W  = 6;
    localparam int ACC_W    = 32;
    localparam int WIDE_W   = 64;
    localparam int BYTE_W   = 8;
    // |w * (a - zp)| <= 128 * 255, fits 17 bits signed
    localparam int TERM_W   = 17;

    // Front/back queue depth default.
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_ZP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_ZP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACT_CLAMP = 2'd2;

    // Upper output clamp.
    localparam logic [BYTE_W-1:0] OUT_MAX = 8'd255;

    // One classified element on its way from front to back.
    typedef struct packed {
        logic signed [TERM_W-1:0]  term;
        logic                      last;
        logic signed [MULT_W-1:0]  multiplier;
        logic signed [OFFS_W-1:0]  offset_term;
        logic        [SHIFT_W-1:0] shift_amount;
    } qcmr_entry_t;

endpackage

// ----- rtl/core/quantized_conv_mac_requantize.sv -----
// Top level of the quantized convolution MAC with requantization.
`timescale 1ns / 1ps

// Each item is one window element (activation byte or padding flag, signed
// weight, last mark, plus the per-channel multiplier, offset and shift). The
// front end takes one item per cycle while the queue is not full, forms
// weight * (activation - input zp), zero for padding, and pushes it into a
// QueueDepth-entry queue. The back end drains that queue into a 32-bit
// wrapping accumulator at one element per cycle, save for the last-element
// wait below. A last element hands the final sum to the requantize
// sequencer: 32x32 multiply, add offset, arithmetic shift and clamp to
// [lower, 255], as the steps multiply, add and output; the byte then sits in
// an output register until taken. The sequencer handles one window at a
// time, so a last element waits in the queue while the previous window's
// requantize is still running or its byte still blocks the output register.
// Windows of four or more elements sustain one item per cycle while the
// output is not stalled; back-to-back single-element windows each wait for
// the previous requantize to finish. Config writes (index 0 input zp, 1 output
// zp, 2 activation clamp; other indexes ignored) are always accepted and must only be issued while the block is idle.

module quantized_conv_mac_requantize
    import qcmr_pkg::*;
#(
    parameter int QueueDepth = QUEUE_DEPTH
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [BYTE_W-1:0]         cfg_wdata,
    // input items
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic        [ACT_W-1:0]   s_activation,
    input  logic                      s_is_padding,
    input  logic signed [WGT_W-1:0]   s_weight,
    input  logic                      s_last_element,
    input  logic signed [MULT_W-1:0]  s_multiplier,
    input  logic signed [OFFS_W-1:0]  s_offset_term,
    input  logic        [SHIFT_W-1:0] s_shift_amount,
    // result items
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [BYTE_W-1:0]         m_output_byte
);

    logic [BYTE_W-1:0] in_zp_reg;
    logic [BYTE_W-1:0] out_zp_reg;
    logic              act_clamp_reg;

    qcmr_entry_t push_entry;
    qcmr_entry_t head;
    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_empty;

    // Register file: always ready; every write is registered on the edge that accepts it.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_zp_reg     <= '0;
            out_zp_reg    <= '0;
            act_clamp_reg <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_INPUT_ZP:  in_zp_reg     <= cfg_wdata;
                CFG_OUTPUT_ZP: out_zp_reg    <= cfg_wdata;
                CFG_ACT_CLAMP: act_clamp_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    qcmr_front u_front (
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_activation     (s_activation),
        .s_is_padding     (s_is_padding),
        .s_weight         (s_weight),
        .s_last_element   (s_last_element),
        .s_multiplier     (s_multiplier),
        .s_offset_term    (s_offset_term),
        .s_shift_amount   (s_shift_amount),
        .input_zero_point (in_zp_reg),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_entry          (push_entry)
    );

    qcmr_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head       (head),
        .empty      (q_empty)
    );

    qcmr_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .head              (head),
        .q_empty           (q_empty),
        .q_pop             (q_pop),
        .output_zero_point (out_zp_reg),
        .activation_clamp  (act_clamp_reg),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_output_byte     (m_output_byte)
    );

endmodule

// ----- rtl/core/qcmr_front.sv -----
// Front end: accepts items and forms the zero-point corrected product term.
`timescale 1ns / 1ps

module qcmr_front
    import qcmr_pkg::*;
(
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic        [ACT_W-1:0]   s_activation,
    input  logic                      s_is_padding,
    input  logic signed [WGT_W-1:0]   s_weight,
    input  logic                      s_last_element,
    input  logic signed [MULT_W-1:0]  s_multiplier,
    input  logic signed [OFFS_W-1:0]  s_offset_term,
    input  logic        [SHIFT_W-1:0] s_shift_amount,
    input  logic        [ACT_W-1:0]   input_zero_point,
    input  logic                      q_full,
    output logic                      q_push,
    output qcmr_entry_t               q_entry
);

    logic        [ACT_W:0]    diff;
    logic signed [TERM_W-1:0] prod;

    // 9-bit difference never overflows: -255..255
    assign diff = {1'b0, s_activation} - {1'b0, input_zero_point};
    assign prod = $signed(diff) * s_weight;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_entry.term         = s_is_padding ? '0 : prod;
        q_entry.last         = s_last_element;
        q_entry.multiplier   = s_multiplier;
        q_entry.offset_term  = s_offset_term;
        q_entry.shift_amount = s_shift_amount;
    end

endmodule

// ----- rtl/core/qcmr_queue.sv -----
// Small FIFO of classified elements between front and back.
`timescale 1ns / 1ps

module qcmr_queue
    import qcmr_pkg::*;
#(
    parameter int Depth = QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  qcmr_entry_t push_entry,
    output logic        full,
    input  logic        pop,
    output qcmr_entry_t head,
    output logic        empty
);

    localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CNT_W = $clog2(Depth + 1);

    qcmr_entry_t      mem [Depth];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == CNT_W'(Depth));
    assign empty = (cnt_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- rtl/core/qcmr_back.sv -----
// Back end: accumulator, three-step requantize sequencer and output register.
`timescale 1ns / 1ps

module qcmr_back
    import qcmr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  qcmr_entry_t       head,
    input  logic              q_empty,
    output logic              q_pop,
    input  logic [BYTE_W-1:0] output_zero_point,
    input  logic              activation_clamp,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_output_byte
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_ADD  = 2'd2;
    localparam logic [1:0] PH_OUT  = 2'd3;

    logic [1:0]               phase_reg, phase_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [ACC_W-1:0]  sum_reg;
    logic signed [MULT_W-1:0] mult_reg;
    logic signed [OFFS_W-1:0] offs_reg;
    logic [SHIFT_W-1:0]       shift_reg;
    logic signed [WIDE_W-1:0] prod_reg;
    logic signed [WIDE_W-1:0] val_reg;
    logic                     out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]        out_byte_reg;

    logic signed [ACC_W-1:0]  term_ext;
    logic signed [ACC_W-1:0]  acc_sum;
    logic signed [WIDE_W-1:0] shifted;
    logic signed [WIDE_W-1:0] lower;
    logic [BYTE_W-1:0]        clamped;
    logic                     out_load;

    assign term_ext = ACC_W'(head.term);
    assign acc_sum  = acc_reg + term_ext;

    // A last element needs the requantize unit free; others drain every cycle.
    assign q_pop = !q_empty && (!head.last || (phase_reg == PH_IDLE));

    assign shifted = val_reg >>> shift_reg;
    assign lower   = activation_clamp ? WIDE_W'(output_zero_point) : '0;

    always_comb begin
        if (shifted < lower) begin
            clamped = lower[BYTE_W-1:0];
        end else if (shifted > WIDE_W'(OUT_MAX)) begin
            clamped = OUT_MAX;
        end else begin
            clamped = shifted[BYTE_W-1:0];
        end
    end

    assign out_load = (phase_reg == PH_OUT) && (!out_valid_reg || m_ready);

    always_comb begin
        acc_next = acc_reg;
        if (q_pop) begin
            acc_next = head.last ? '0 : acc_sum;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_IDLE: begin
                if (q_pop && head.last) begin
                    phase_next = PH_MUL;
                end
            end
            PH_MUL:  phase_next = PH_ADD;
            PH_ADD:  phase_next = PH_OUT;
            PH_OUT: begin
                if (out_load) begin
                    phase_next = PH_IDLE;
                end
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers, no reset
    always_ff @(posedge aclk) begin
        if (q_pop && head.last) begin
            sum_reg   <= acc_sum;
            mult_reg  <= head.multiplier;
            offs_reg  <= head.offset_term;
            shift_reg <= head.shift_amount;
        end
        if (phase_reg == PH_MUL) begin
            prod_reg <= WIDE_W'(mult_reg) * WIDE_W'(sum_reg);
        end
        if (phase_reg == PH_ADD) begin
            val_reg <= prod_reg + WIDE_W'(offs_reg);
        end
        if (out_load) begin
            out_byte_reg <= clamped;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_output_byte = out_byte_reg;

endmodule

// ----- rtl/core/qcmr_checker.sv -----
// Port-level checker for the quantized conv MAC block, bound to the top level.
`timescale 1ns / 1ps

module qcmr_checker
    import qcmr_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              s_last_element,
    input logic              m_valid,
    input logic              m_ready,
    input logic [BYTE_W-1:0] m_output_byte
);

    // windows closed at the input but not yet delivered
    logic [7:0] pend_reg;
    logic       last_in;
    logic       res_out;

    assign last_in = s_valid && s_ready && s_last_element;
    assign res_out = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else if (last_in && !res_out) begin
            pend_reg <= pend_reg + 1'b1;
        end else if (res_out && !last_in) begin
            pend_reg <= pend_reg - 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_output_byte))
        else $error("result changed while stalled");

    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pend_reg != 8'd0)
        else $error("result without a closed window");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind quantized_conv_mac_requantize qcmr_checker u_qcmr_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_last_element (s_last_element),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_output_byte  (m_output_byte)
);

// ----- dv/tb.sv -----
// Self-checking testbench for the quantized conv MAC / requantize block.
`timescale 1ns / 1ps

module tb;
    import qcmr_pkg::*;

    // Clock period 20 ns; the watchdog ends the run after this many ns.
    localparam longint RUN_LIMIT_NS = 64'd20_000_000;
    // Cycles to let the element queue and requantize pipe empty before
    // a config write (queue depth 4, 3-stage requantize, output reg).
    localparam int     SETTLE_CYCLES = 16;
    // A 2-bit index covers one slot past the register list; writes there
    // must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
    // Count of non-last elements in the long window of max-magnitude terms; a last element follows.
    localparam int     WRAP_ELEMS = 64;

    // Tracks the block's config and running window sum, and holds the
    // output bytes still owed by the block, oldest first.
    class mac_requant_sb;
        logic [BYTE_W-1:0] in_zp;
        logic [BYTE_W-1:0] out_zp;
        logic              clamp_on;
        int                window_sum;
        logic [BYTE_W-1:0] bytes_due[$];

        function new();
            in_zp      = '0;
            out_zp     = '0;
            clamp_on   = 1'b0;
            window_sum = 0;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [BYTE_W-1:0] data);
            case (idx)
                CFG_INPUT_ZP:  in_zp    = data;
                CFG_OUTPUT_ZP: out_zp   = data;
                CFG_ACT_CLAMP: clamp_on = data[0];
                default: ;
            endcase
        endfunction

        // Accumulate one accepted element; on a last mark, requantize
        // and queue the byte that the block owes.
        function void note_element(input logic [ACT_W-1:0] act,
                                   input logic pad,
                                   input logic signed [WGT_W-1:0] wgt,
                                   input logic last,
                                   input logic signed [MULT_W-1:0] mult,
                                   input logic signed [OFFS_W-1:0] offs,
                                   input logic [SHIFT_W-1:0] sh);
            int     prod;
            longint scaled;
            longint floor_val;
            if (!pad) begin
                prod       = int'(wgt) * (int'(act) - int'(in_zp));
                window_sum = window_sum + prod;   // wraps mod 2^32
            end
            if (last) begin
                // full 64-bit value is clamped, never cut to 32 bits
                scaled    = longint'(mult) * longint'(window_sum) + longint'(offs);
                scaled    = scaled >>> sh;
                floor_val = clamp_on ? longint'(out_zp) : 64'sd0;
                if (scaled < floor_val) scaled = floor_val;
                if (scaled > 64'sd255) scaled = 64'sd255;
                bytes_due.push_back(scaled[BYTE_W-1:0]);
                window_sum = 0;
            end
        endfunction

        function bit match_byte(input logic [BYTE_W-1:0] got, output string why);
            logic [BYTE_W-1:0] want;
            why = "";
            if (bytes_due.size() == 0) begin
                why = $sformatf("output byte %0d with none owed", got);
                return 1'b0;
            end
            want = bytes_due.pop_front();
            if (got !== want) begin
                why = $sformatf("output_byte got %0d want %0d", got, want);
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function int owed();
            return bytes_due.size();
        endfunction
    endclass

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [BYTE_W-1:0]         cfg_wdata;
    logic                      s_valid;
    logic                      s_ready;
    logic        [ACT_W-1:0]   s_activation;
    logic                      s_is_padding;
    logic signed [WGT_W-1:0]   s_weight;
    logic                      s_last_element;
    logic signed [MULT_W-1:0]  s_multiplier;
    logic signed [OFFS_W-1:0]  s_offset_term;
    logic        [SHIFT_W-1:0] s_shift_amount;
    logic                      m_valid;
    logic                      m_ready;
    logic [BYTE_W-1:0]         m_output_byte;

    mac_requant_sb sb;
    int            mismatch_count = 0;
    // Pacing knobs: percent of elements before which the sender idles, percent of
    // cycles the receiver stalls, plus a one-off receiver hold-off counted down in the receiver's own process.
    int            send_idle_pct = 30;
    int            recv_stall_pct = 30;
    int            hold_cycles = 0;
    string         why;

    quantized_conv_mac_requantize dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_activation   (s_activation),
        .s_is_padding   (s_is_padding),
        .s_weight       (s_weight),
        .s_last_element (s_last_element),
        .s_multiplier   (s_multiplier),
        .s_offset_term  (s_offset_term),
        .s_shift_amount (s_shift_amount),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_output_byte  (m_output_byte)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    task automatic flag_error(input string msg);
        mismatch_count++;
        $display("%0t ERROR %s", $time, msg);
    endtask

    // Input side is observed at the edge, so the predictor sees exactly
    // what the block took.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.note_element(s_activation, s_is_padding, s_weight, s_last_element,
                            s_multiplier, s_offset_term, s_shift_amount);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (!sb.match_byte(m_output_byte, why))
                flag_error(why);
        end
    end

    // Receiver: random stalls, or a long hold-off when requested.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                hold_cycles--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Change knobs at a rising edge so the receiver never races with it.
    task automatic set_pacing(input int idle_pct, input int stall_pct, input int hold);
        @(posedge aclk);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        hold_cycles    = hold;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        sb.write_reg(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [BYTE_W-1:0] izp, input logic [BYTE_W-1:0] ozp,
                             input logic clamp);
        write_reg(CFG_INPUT_ZP, izp);
        write_reg(CFG_OUTPUT_ZP, ozp);
        write_reg(CFG_ACT_CLAMP, {7'd0, clamp});
    endtask

    // Offer one element; valid stays up until the block takes it.
    task automatic send_elem(input logic [ACT_W-1:0] act, input logic pad,
                             input logic signed [WGT_W-1:0] wgt, input logic last,
                             input logic signed [MULT_W-1:0] mult,
                             input logic signed [OFFS_W-1:0] offs,
                             input logic [SHIFT_W-1:0] sh);
        int gap;
        @(negedge aclk);
        if ($urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(1, 4);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_activation   <= act;
        s_is_padding   <= pad;
        s_weight       <= wgt;
        s_last_element <= last;
        s_multiplier   <= mult;
        s_offset_term  <= offs;
        s_shift_amount <= sh;
        do @(posedge aclk); while (s_ready !== 1'b1);
    endtask

    // Drop valid, wait for every owed byte, then let the pipe empty.
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.owed() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One output channel's window with random content. Two in three use
    // realistic requant params so outputs land inside 0..255; the rest
    // take raw random multiplier, offset and shift.
    task automatic send_window(input int len);
        logic signed [MULT_W-1:0] mult;
        logic signed [OFFS_W-1:0] offs;
        logic        [SHIFT_W-1:0] sh;
        int k;
        if ($urandom_range(2) == 0) begin
            mult = $urandom();
            offs = OFFS_W'({$urandom(), $urandom()});
            sh   = SHIFT_W'($urandom_range(63));
        end else begin
            sh   = SHIFT_W'($urandom_range(28, 44));
            mult = $urandom_range(32'h7FFF_FFFF);
            if ($urandom_range(3) == 0) mult = -mult;
            offs = OFFS_W'((longint'($urandom_range(400)) - 64'sd150)
                           <<< ((sh > 6'd38) ? 6'd38 : sh));
        end
        for (k = 0; k < len; k++)
            send_elem(ACT_W'($urandom_range(255)), ($urandom_range(99) < 15),
                      WGT_W'($urandom_range(255)), (k == len - 1), mult, offs, sh);
    endtask

    function automatic int pick_window_len();
        int r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(1, 4);
        if (r < 95) return $urandom_range(5, 16);
        return $urandom_range(17, 64);
    endfunction

    initial begin
        int phase;
        int sent;
        int len;
        logic [BYTE_W-1:0] izp;
        logic [BYTE_W-1:0] ozp;
        logic              clamp;

        sb = new();
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_activation   = '0;
        s_is_padding   = 1'b0;
        s_weight       = '0;
        s_last_element = 1'b0;
        s_multiplier   = '0;
        s_offset_term  = '0;
        s_shift_amount = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // --- directed, reset config (zero points 0, clamp off) ---
        // extreme bytes, padding ignored: 127*255 - 128*255 = -255 -> 0
        send_elem(8'd255, 1'b0, 8'sd127, 1'b0, 32'sd0, 48'sd0, 6'd0);
        send_elem(8'd0, 1'b0, -8'sd128, 1'b0, 32'sd0, 48'sd0, 6'd0);
        send_elem(8'd200, 1'b1, -8'sd128, 1'b0, 32'sd0, 48'sd0, 6'd0);
        send_elem(8'd255, 1'b0, -8'sd128, 1'b1, 32'sd1, 48'sd0, 6'd0);
        // single-element window landing mid-range
        send_elem(8'd10, 1'b0, 8'sd5, 1'b1, 32'sd1, 48'sd200, 6'd0);
        // multiplier / offset extremes, upper and lower clamp
        send_elem(8'd255, 1'b0, 8'sd127, 1'b1, 32'sh7FFF_FFFF, 48'sh7FFF_FFFF_FFFF, 6'd0);
        send_elem(8'd255, 1'b0, 8'sd127, 1'b1, 32'sh8000_0000, 48'sh8000_0000_0000, 6'd0);
        // max shift on positive and negative values
        send_elem(8'd255, 1'b0, 8'sd127, 1'b1, 32'sh7FFF_FFFF, 48'sd0, 6'd63);
        send_elem(8'd255, 1'b0, -8'sd128, 1'b1, 32'sh7FFF_FFFF, 48'sd0, 6'd63);
        // wide value: 2^32+16 must clamp to 255, not wrap to 16
        send_elem(8'd1, 1'b0, 8'sd1, 1'b1, 32'sd0, 48'h0001_0000_0010, 6'd0);
        // shift by 32 brings the offset down to 100
        send_elem(8'd3, 1'b0, -8'sd7, 1'b1, 32'sd0, 48'h0064_0000_0000, 6'd32);
        // padded last element: result from an empty sum
        send_elem(8'd77, 1'b1, -8'sd3, 1'b1, 32'sd1, 48'sd50, 6'd0);
        wait_idle();

        // input zp at max, clamp on with output zp 200
        configure(8'd255, 8'd200, 1'b1);
        send_elem(8'd0, 1'b0, 8'sd127, 1'b0, 32'sd0, 48'sd0, 6'd0);
        send_elem(8'd255, 1'b0, -8'sd128, 1'b1, 32'sd1, 48'sd0, 6'd0);
        send_elem(8'd0, 1'b0, -8'sd1, 1'b1, 32'sd1, 48'sd0, 6'd0);
        send_elem(8'd255, 1'b0, 8'sd99, 1'b1, 32'sd1, 48'sd210, 6'd0);
        wait_idle();

        // out-of-range index must not touch any register
        write_reg(CFG_SPARE_IDX, 8'hFF);
        configure(8'd128, 8'd255, 1'b1);
        send_elem(8'd128, 1'b0, 8'sd100, 1'b1, 32'sd1, 48'sd0, 6'd0);
        wait_idle();
        write_reg(CFG_ACT_CLAMP, 8'd0);
        send_elem(8'd128, 1'b0, 8'sd100, 1'b1, 32'sd1, 48'sd0, 6'd0);
        wait_idle();

        // --- a long window of max-magnitude terms ---
        // also the long stretch with no idling on either side
        configure(8'd0, 8'd0, 1'b0);
        set_pacing(0, 0, 0);
        for (int k = 0; k < WRAP_ELEMS; k++)
            send_elem(8'd255, 1'b0, -8'sd128, 1'b0, $urandom(), 48'sd0, 6'd0);
        send_elem(8'd255, 1'b0, -8'sd128, 1'b1, 32'sd1, 48'sd0, 6'd23);
        wait_idle();

        // --- random phases, each with its own register setting ---
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin izp = 8'd0;   ozp = 8'd0;   clamp = 1'b0; end
                1: begin izp = 8'd255; ozp = 8'd255; clamp = 1'b1; end
                2: begin izp = 8'd0;   ozp = 8'd255; clamp = 1'b0; end
                3: begin izp = 8'd255; ozp = 8'd0;   clamp = 1'b1; end
                default: begin
                    izp   = BYTE_W'($urandom_range(255));
                    ozp   = BYTE_W'($urandom_range(255));
                    clamp = 1'($urandom_range(1));
                end
            endcase
            configure(izp, ozp, clamp);
            // phase 1: receiver holds off long enough to back up the block
            // phase 3: no idling either side
            if (phase == 1)
                set_pacing(30, 30, 300);
            else if (phase == 3)
                set_pacing(0, 0, 0);
            else
                set_pacing(30, 30, 0);
            sent = 0;
            while (sent < 250) begin
                len = pick_window_len();
                send_window(len);
                sent += len;
            end
            wait_idle();
        end

        if (sb.owed() != 0)
            flag_error($sformatf("%0d output bytes never arrived", sb.owed()));
        if (mismatch_count == 0) begin
            $display("quantized_conv_mac_requantize test passed");
        end else begin
            $display("quantized_conv_mac_requantize test failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(RUN_LIMIT_NS);
        $display("quantized_conv_mac_requantize test failed");
        $finish;
    end

endmodule
